// ----- src/aligned_pair_identity_defines.svh -----
// ---------------------------------------------------------------------------
// aligned_pair_identity_defines.svh
// Assertion macros shared by the pair identity RTL.
// ---------------------------------------------------------------------------
`ifndef ALIGNED_PAIR_IDENTITY_DEFINES_SVH
`define ALIGNED_PAIR_IDENTITY_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define APID_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define APID_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/apid_pkg.sv -----
// ---------------------------------------------------------------------------
// apid_pkg
// Types and constants for the aligned pair identity block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package apid_pkg;

  localparam int RES_W           = 8;
  localparam int Q_W             = 17;
  localparam int MAX_COLUMNS_DEF = 65536;
  localparam int DIV_STEPS       = Q_W;  // one quotient bit per step

  localparam logic [RES_W-1:0] GAP_CHAR     = 8'd45;   // '-'
  localparam logic [Q_W-1:0]   ONE_Q16      = 17'h10000;
  localparam logic [Q_W-1:0]   THRESH_RESET = 17'd45875;

  typedef struct packed {
    logic [RES_W-1:0] residue_a;
    logic [RES_W-1:0] residue_b;
    logic             last_column;
  } in_item_t;

  typedef struct packed {
    logic [Q_W-1:0] match_count;
    logic [Q_W-1:0] length_a;
    logic [Q_W-1:0] length_b;
    logic [Q_W-1:0] identity_a;
    logic [Q_W-1:0] identity_b;
    logic           above_a;
    logic           above_b;
  } out_item_t;

  typedef struct packed {
    logic           done;
    logic           rem_nz;
    logic [Q_W-1:0] quot;
  } div_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_A,
    ST_WAIT_A,
    ST_LOAD_B,
    ST_WAIT_B
  } state_t;

endpackage

// ----- src/apid_cnt.sv -----
// ---------------------------------------------------------------------------
// apid_cnt
// Per-column counters: non-gap columns of each sequence and matching columns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module apid_cnt #(
  parameter int MAX_COLUMNS = apid_pkg::MAX_COLUMNS_DEF,
  parameter int CNT_W       = $clog2(MAX_COLUMNS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  apid_pkg::in_item_t  item,
  output logic [CNT_W-1:0]    m_now,
  output logic [CNT_W-1:0]    la_now,
  output logic [CNT_W-1:0]    lb_now
);

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_COLUMNS);

  logic [CNT_W-1:0] match_cnt;
  logic [CNT_W-1:0] nongap_a;
  logic [CNT_W-1:0] nongap_b;
  logic             gap_a;
  logic             gap_b;
  logic             hit;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v >= MAX_C) ? MAX_C : v + 1'b1;
  endfunction

  // counts including the column on the inputs now
  always_comb begin
    gap_a  = (item.residue_a == apid_pkg::GAP_CHAR);
    gap_b  = (item.residue_b == apid_pkg::GAP_CHAR);
    hit    = !gap_a && !gap_b && (item.residue_a == item.residue_b);
    la_now = gap_a ? nongap_a : sat_inc(nongap_a);
    lb_now = gap_b ? nongap_b : sat_inc(nongap_b);
    m_now  = hit ? sat_inc(match_cnt) : match_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_cnt <= '0;
      nongap_a  <= '0;
      nongap_b  <= '0;
    end else if (accept) begin
      if (item.last_column) begin
        match_cnt <= '0;
        nongap_a  <= '0;
        nongap_b  <= '0;
      end else begin
        match_cnt <= m_now;
        nongap_a  <= la_now;
        nongap_b  <= lb_now;
      end
    end
  end

endmodule

// ----- src/apid_div.sv -----
// ---------------------------------------------------------------------------
// apid_div
// Shared restoring divider: floor(num * 2^16 / den), one quotient bit a cycle.
// Needs num <= den; den held stable while running.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aligned_pair_identity_defines.svh"

module apid_div #(
  parameter int CNT_W = $clog2(apid_pkg::MAX_COLUMNS_DEF + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CNT_W-1:0]   num,
  input  logic [CNT_W-1:0]   den,
  output apid_pkg::div_res_t res
);

  localparam int STEP_W = $clog2(apid_pkg::DIV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(apid_pkg::DIV_STEPS - 1);

  logic                     running;
  logic                     done;
  logic [STEP_W-1:0]        step;
  logic [CNT_W-1:0]         rem;
  logic [apid_pkg::Q_W-1:0] quot;
  logic [CNT_W:0]           trial;
  logic [CNT_W:0]           diff;
  logic                     ge;

  // first step tests num itself (quotient bit 16), then shift-and-subtract
  always_comb begin
    trial = (step == '0) ? {1'b0, rem} : {rem, 1'b0};
    ge    = (trial >= {1'b0, den});
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      quot <= '0;
    end else if (running) begin
      rem  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quot <= {quot[apid_pkg::Q_W-2:0], ge};
    end
  end

  assign res.done   = done;
  assign res.rem_nz = (rem != '0);
  assign res.quot   = quot;

  `APID_ASSERT_IMP(a_div_start_idle, clk, rst, start, !running, "divider restarted while busy")
  `APID_ASSERT_NXT(a_div_done_pulse, clk, rst, done, !done && !running, "done not a single pulse")
  `APID_ASSERT_IMP(a_div_step_bound, clk, rst, running, step <= LAST_STEP, "divider step overrun")

endmodule

// ----- src/aligned_pair_identity.sv -----
// ---------------------------------------------------------------------------
// aligned_pair_identity
// Pairwise identity of two aligned sequences, one column per item.
// ---------------------------------------------------------------------------
// Columns are taken one per cycle while busy is low. After the column with
// last_column set, busy stays high while one shared 17-step divider computes
// identity_a and then identity_b.
// The result then appears for a single cycle with result_valid; it is not
// held, so the receiver must take it in that cycle. The threshold flags come
// from the same divider's quotient and remainder, with no multiplier.
// The threshold register may be written only while the block is idle.
`timescale 1ns / 1ps
`include "aligned_pair_identity_defines.svh"

module aligned_pair_identity #(
  parameter int MAX_COLUMNS = apid_pkg::MAX_COLUMNS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  apid_pkg::in_item_t       item,
  output logic                     busy,
  input  logic                     cfg_we,
  input  logic [apid_pkg::Q_W-1:0] cfg_data,
  output logic                     result_valid,
  output apid_pkg::out_item_t      result
);

  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int Q_W   = apid_pkg::Q_W;

  apid_pkg::state_t   state;
  apid_pkg::state_t   state_next;
  apid_pkg::div_res_t div_res;

  logic             accept;
  logic [CNT_W-1:0] m_now;
  logic [CNT_W-1:0] la_now;
  logic [CNT_W-1:0] lb_now;
  logic [CNT_W-1:0] snap_m;
  logic [CNT_W-1:0] snap_la;
  logic [CNT_W-1:0] snap_lb;
  logic [CNT_W-1:0] den;
  logic [Q_W-1:0]   threshold;
  logic [Q_W-1:0]   id_cur;
  logic             above_cur;
  logic [Q_W-1:0]   id_a;
  logic             above_a;
  logic             div_start;
  logic             sel_b;

  assign busy   = (state != apid_pkg::ST_IDLE);
  assign accept = start && !busy;

  apid_cnt #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .CNT_W      (CNT_W)
  ) u_cnt (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (item),
    .m_now (m_now),
    .la_now(la_now),
    .lb_now(lb_now)
  );

  assign sel_b = (state == apid_pkg::ST_LOAD_B) || (state == apid_pkg::ST_WAIT_B);
  assign den   = sel_b ? snap_lb : snap_la;

  apid_div #(
    .CNT_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (snap_m),
    .den  (den),
    .res  (div_res)
  );

  // m*2^16 = q*len + r, so m*2^16 > thr*len exactly when q > thr, or q == thr and r != 0
  always_comb begin
    id_cur    = (den == '0) ? '0 : div_res.quot;
    above_cur = (den != '0) &&
                ((div_res.quot > threshold) ||
                 ((div_res.quot == threshold) && div_res.rem_nz));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apid_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      apid_pkg::ST_IDLE: begin
        if (accept && item.last_column) begin
          state_next = apid_pkg::ST_LOAD_A;
        end
      end
      apid_pkg::ST_LOAD_A: begin
        div_start  = 1'b1;
        state_next = apid_pkg::ST_WAIT_A;
      end
      apid_pkg::ST_WAIT_A: begin
        if (div_res.done) begin
          state_next = apid_pkg::ST_LOAD_B;
        end
      end
      apid_pkg::ST_LOAD_B: begin
        div_start  = 1'b1;
        state_next = apid_pkg::ST_WAIT_B;
      end
      apid_pkg::ST_WAIT_B: begin
        if (div_res.done) begin
          state_next = apid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = apid_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= apid_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == apid_pkg::ST_WAIT_B) && div_res.done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.last_column) begin
      snap_m  <= m_now;
      snap_la <= la_now;
      snap_lb <= lb_now;
    end
    if ((state == apid_pkg::ST_WAIT_A) && div_res.done) begin
      id_a    <= id_cur;
      above_a <= above_cur;
    end
    if ((state == apid_pkg::ST_WAIT_B) && div_res.done) begin
      result.match_count <= Q_W'(snap_m);
      result.length_a    <= Q_W'(snap_la);
      result.length_b    <= Q_W'(snap_lb);
      result.identity_a  <= id_a;
      result.identity_b  <= id_cur;
      result.above_a     <= above_a;
      result.above_b     <= above_cur;
    end
  end

  `APID_ASSERT_IMP(a_res_after_div, clk, rst, result_valid, !busy && ($past(state) == apid_pkg::ST_WAIT_B), "result without finished division")
  `APID_ASSERT_NXT(a_last_goes_busy, clk, rst, accept && item.last_column, busy, "last column did not start division")
  `APID_ASSERT_IMP(a_id_range, clk, rst, result_valid, (result.identity_a <= apid_pkg::ONE_Q16) && (result.identity_b <= apid_pkg::ONE_Q16), "identity above one")

endmodule
